[src/fqcs_pkg.sv]
// shared types and constants for the q31 fir with split compute and shift
`timescale 1ns / 1ps

package fqcs_pkg;

    localparam int DATA_W   = 32;
    localparam int TAPCNT_W = 7;
    localparam int IDX_W    = 6;
    localparam int KIND_W   = 2;

    localparam logic [KIND_W-1:0] KIND_FILTER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHIFT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COEF   = 2'd2;

    localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = 7'd2;
    localparam logic [TAPCNT_W-1:0] TAPCNT_MIN   = 7'd2;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RUN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

[src/fir_q31_split_compute_shift.sv]
// q31 fir filter top level: one shared multiply-accumulate under a small sequencer
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_kind, i_sample, i_coef_index,
//          |           |                            | i_coef_value
//  out     | output    | o_out_valid / i_out_stall  | o_filtered
//  cfg     | input     | i_cfg_we                   | i_cfg_data (tap count)
//
// a filter beat keeps the input stalled until its result is loaded, with n effective taps:
// the single 32x32 multiplier takes one coefficient and one history word per cycle, the new
// sample in place of history for the last tap; the product register and the accumulator
// follow, and the output register is loaded last. shift and coefficient beats do not stall.
// after reset a clearing pass zeroes both memories; no beat
// is taken meanwhile, configuration writes still are.
// a finished result waits in the output register while the next beat is taken;
// a filter result that finds the output register still full waits for it.
`timescale 1ns / 1ps

module fir_q31_split_compute_shift #(
    parameter int MAX_TAPS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [fqcs_pkg::KIND_W-1:0]           i_kind,
    input  logic signed [fqcs_pkg::DATA_W-1:0]    i_sample,
    input  logic [fqcs_pkg::IDX_W-1:0]            i_coef_index,
    input  logic signed [fqcs_pkg::DATA_W-1:0]    i_coef_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [fqcs_pkg::DATA_W-1:0]    o_filtered,
    input  logic                                  i_cfg_we,
    input  logic [fqcs_pkg::TAPCNT_W-1:0]         i_cfg_data
);
    import fqcs_pkg::*;

    localparam int HIST_D = MAX_TAPS - 1;
    localparam int CW     = $clog2(MAX_TAPS);
    localparam int HW     = (HIST_D > 1) ? $clog2(HIST_D) : 1;
    localparam int NW     = $clog2(MAX_TAPS + 1);

    logic signed [DATA_W-1:0] coef_mem [MAX_TAPS];
    logic signed [DATA_W-1:0] hist_mem [HIST_D];

    t_state                   r_state;
    logic [TAPCNT_W-1:0]      r_tap_count;
    logic [CW-1:0]            r_clr;
    logic [HW-1:0]            r_wp;
    logic [HW-1:0]            r_haddr;
    logic [NW-1:0]            r_step;
    logic [NW-1:0]            r_nm1;
    logic                     r_s1_vld;
    logic                     r_s1_last;
    logic                     r_s2_vld;
    logic                     r_s2_last;
    logic                     r_out_valid;

    logic signed [DATA_W-1:0]   r_sample;
    logic signed [DATA_W-1:0]   r_hist_rd;
    logic signed [DATA_W-1:0]   r_coef_rd;
    logic signed [2*DATA_W-1:0] r_prod;
    logic [DATA_W-1:0]          r_acc;
    logic [DATA_W-1:0]          r_filtered;

    logic                     in_acc;
    logic                     out_acc;
    logic                     out_load;
    logic [NW-1:0]            n_eff;
    logic [NW-1:0]            nm1;
    logic [HW-1:0]            start_addr;
    logic [HW-1:0]            n_haddr;
    logic [HW-1:0]            n_wp;
    logic                     coef_we;
    logic [CW-1:0]            coef_waddr;
    logic signed [DATA_W-1:0] coef_wdata;
    logic                     hist_we;
    logic [HW-1:0]            hist_waddr;
    logic signed [DATA_W-1:0] hist_wdata;
    logic signed [DATA_W-1:0] x_op;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

    // effective tap count and oldest history address
    always_comb begin
        if (r_tap_count < TAPCNT_MIN) begin
            n_eff = NW'(2);
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            n_eff = NW'(MAX_TAPS);
        end else begin
            n_eff = NW'(r_tap_count);
        end
        nm1 = n_eff - NW'(1);
        if (32'(r_wp) >= 32'(nm1)) begin
            start_addr = HW'(32'(r_wp) - 32'(nm1));
        end else begin
            start_addr = HW'(32'(r_wp) + HIST_D - 32'(nm1));
        end
    end

    assign n_haddr = (32'(r_haddr) == HIST_D - 1) ? '0 : r_haddr + HW'(1);
    assign n_wp    = (32'(r_wp) == HIST_D - 1) ? '0 : r_wp + HW'(1);

    // memory write ports
    always_comb begin
        coef_we    = 1'b0;
        coef_waddr = r_clr;
        coef_wdata = '0;
        hist_we    = 1'b0;
        hist_waddr = HW'(r_clr);
        hist_wdata = '0;
        if (r_state == S_CLEAR) begin
            coef_we = 1'b1;
            hist_we = (32'(r_clr) < HIST_D);
        end else if (in_acc) begin
            case (i_kind)
                KIND_SHIFT: begin
                    hist_we    = 1'b1;
                    hist_waddr = r_wp;
                    hist_wdata = i_sample;
                end
                KIND_COEF: begin
                    coef_we    = (32'(i_coef_index) < MAX_TAPS);
                    coef_waddr = CW'(i_coef_index);
                    coef_wdata = i_coef_value;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        r_coef_rd <= coef_mem[CW'(r_step)];
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        r_hist_rd <= hist_mem[r_haddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_tap_count <= TAPCNT_RESET;
            r_clr       <= '0;
            r_wp        <= '0;
            r_haddr     <= '0;
            r_step      <= '0;
            r_nm1       <= NW'(1);
            r_s1_vld    <= 1'b0;
            r_s1_last   <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s2_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_data;
            end
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_last;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CW'(1);
                    if (32'(r_clr) == MAX_TAPS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_kind)
                            KIND_FILTER: begin
                                r_state <= S_RUN;
                                r_step  <= '0;
                                r_nm1   <= nm1;
                                r_haddr <= start_addr;
                            end
                            KIND_SHIFT: begin
                                r_wp <= n_wp;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    r_s1_vld  <= 1'b1;
                    r_s1_last <= (r_step == r_nm1);
                    r_haddr   <= n_haddr;
                    if (r_step == r_nm1) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= r_step + NW'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_s2_vld && r_s2_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // shared multiply-accumulate datapath
    assign x_op = r_s1_last ? r_sample : r_hist_rd;

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_kind == KIND_FILTER)) begin
            r_sample <= i_sample;
            r_acc    <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_acc + r_prod[2*DATA_W-1:DATA_W] + DATA_W'(r_prod[DATA_W-1]);
        end
        r_prod <= x_op * r_coef_rd;
        if (out_load) begin
            r_filtered <= {r_acc[DATA_W-2:0], 1'b0};
        end
    end

    a_s1_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> $past(r_state == S_RUN))
        else $error("product stage fed outside the tap sweep");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_step <= r_nm1))
        else $error("tap counter ran past the tap count");

    a_filter_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == KIND_FILTER) |=> (r_state == S_RUN))
        else $error("filter beat did not start the tap sweep");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result shown without a finished sweep");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && r_s2_vld && r_s2_last) |=> (r_state == S_DONE))
        else $error("last product did not close the sweep");

endmodule

[dv/fir_q31_split_compute_shift_tb.sv]
// self-checking testbench for the q31 fir with split compute and shift beats
`timescale 1ns / 1ps

module fir_q31_split_compute_shift_tb;
    import fqcs_pkg::*;

    localparam int MAX_TAPS = 64;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 2 * MAX_TAPS + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES = 10;
    localparam int BEATS_PER_PHASE = 125;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [KIND_W-1:0]   in_kind = KIND_FILTER;
    logic [DATA_W-1:0]   in_sample = '0;
    logic [IDX_W-1:0]    in_coef_index = '0;
    logic [DATA_W-1:0]   in_coef_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DATA_W-1:0]   filtered;
    logic                cfg_we = 1'b0;
    logic [TAPCNT_W-1:0] cfg_data = '0;

    // filter model state
    logic [DATA_W-1:0]   hist_line [MAX_TAPS-1];
    logic [DATA_W-1:0]   coef_bank [MAX_TAPS];
    logic [TAPCNT_W-1:0] tap_reg;
    logic [DATA_W-1:0]   expected_filtered [$];
    logic [DATA_W-1:0]   front_filtered;

    bit calm = 1'b0;
    int mismatches = 0;
    int beats_sent = 0;
    int results_checked = 0;
    int taps_written = 0;
    int quiet_cycles = 0;

    fir_q31_split_compute_shift #(
        .MAX_TAPS(MAX_TAPS)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_kind       (in_kind),
        .i_sample     (in_sample),
        .i_coef_index (in_coef_index),
        .i_coef_value (in_coef_value),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_filtered   (filtered),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] rounded_high_word(input logic [DATA_W-1:0] a,
                                                            input logic [DATA_W-1:0] b);
        logic signed [63:0] ax;
        logic signed [63:0] bx;
        logic signed [63:0] prod;
        logic [63:0]        biased;
        ax = $signed(a);
        bx = $signed(b);
        prod = ax * bx;
        biased = prod + 64'h0000_0000_8000_0000;
        return biased[63:32];
    endfunction

    function automatic int effective_taps();
        if (tap_reg < TAPCNT_MIN) begin
            return int'(TAPCNT_MIN);
        end
        if (int'(tap_reg) > MAX_TAPS) begin
            return MAX_TAPS;
        end
        return int'(tap_reg);
    endfunction

    function automatic logic [DATA_W-1:0] filter_output(input logic [DATA_W-1:0] x);
        int                n;
        int                base;
        logic [DATA_W-1:0] acc;
        n = effective_taps();
        base = MAX_TAPS - 1 - (n - 1);
        acc = '0;
        for (int i = 0; i < n - 1; i++) begin
            acc += rounded_high_word(hist_line[base + i], coef_bank[i]);
        end
        acc += rounded_high_word(x, coef_bank[n - 1]);
        return {acc[DATA_W-2:0], 1'b0};
    endfunction

    task automatic track_beat(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] s,
                              input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        case (k)
            KIND_FILTER: begin
                expected_filtered.push_back(filter_output(s));
            end
            KIND_SHIFT: begin
                for (int i = 0; i < MAX_TAPS - 2; i++) begin
                    hist_line[i] = hist_line[i + 1];
                end
                hist_line[MAX_TAPS - 2] = s;
            end
            KIND_COEF: begin
                coef_bank[idx] = v;
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_beat(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] s,
                             input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        int gap;
        if (!calm && $urandom_range(0, 99) < 11) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind <= k;
        in_sample <= s;
        in_coef_index <= idx;
        in_coef_value <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        track_beat(k, s, idx, v);
        beats_sent++;
    endtask

    // lets every pending beat finish, including ones that give no result
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_filtered.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_taps(input logic [TAPCNT_W-1:0] v);
        settle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tap_reg = v;
        taps_written++;
    endtask

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_after_reset();
        settle();
        send_beat(KIND_FILTER, 32'h7fff_ffff, '0, '0);
        send_beat(KIND_FILTER, 32'h8000_0000, 6'd63, 32'hffff_ffff);
        settle();
    endtask

    task automatic test_coefficient_extremes();
        send_beat(KIND_COEF, '0, 6'd0, 32'h8000_0000);
        send_beat(KIND_COEF, 32'hffff_ffff, 6'd1, 32'h8000_0000);
        send_beat(KIND_SHIFT, 32'h8000_0000, '0, '0);
        send_beat(KIND_FILTER, 32'h8000_0000, '0, '0);
        send_beat(KIND_FILTER, 32'h7fff_ffff, '0, '0);
        send_beat(KIND_COEF, '0, 6'd1, 32'h7fff_ffff);
        send_beat(KIND_FILTER, 32'h8000_0000, '0, '0);
        send_beat(KIND_FILTER, 32'hffff_ffff, '0, '0);
        send_beat(KIND_COEF, '0, 6'd63, 32'h7fff_ffff);
        send_beat(KIND_UNUSED, 32'hffff_ffff, 6'd63, 32'hffff_ffff);
        send_beat(KIND_SHIFT, 32'h7fff_ffff, 6'd63, 32'hffff_ffff);
        send_beat(KIND_FILTER, 32'h0000_0000, '0, '0);
        settle();
    endtask

    task automatic test_tap_count_limits();
        logic [TAPCNT_W-1:0] limits [6];
        limits = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd127, TAPCNT_RESET};
        foreach (limits[i]) begin
            set_taps(limits[i]);
            send_beat(KIND_FILTER, random_word(), IDX_W'($urandom), $urandom);
        end
        settle();
    endtask

    task automatic test_random_traffic();
        logic [TAPCNT_W-1:0] taps;
        logic [KIND_W-1:0]   k;
        logic [IDX_W-1:0]    idx;
        int                  r;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            r = $urandom_range(0, 99);
            if (phase == 1) begin
                taps = 7'd64;
            end else if (r < 60) begin
                taps = TAPCNT_W'($urandom_range(2, 8));
            end else if (r < 85) begin
                taps = TAPCNT_W'($urandom_range(9, 32));
            end else begin
                taps = TAPCNT_W'($urandom_range(0, 127));
            end
            set_taps(taps);
            calm = (phase == 3);
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 36) begin
                    k = KIND_FILTER;
                end else if (r < 70) begin
                    k = KIND_SHIFT;
                end else if (r < 95) begin
                    k = KIND_COEF;
                end else begin
                    k = KIND_UNUSED;
                end
                // bias coefficient writes toward taps in use
                if ($urandom_range(0, 1) == 0) begin
                    idx = IDX_W'($urandom_range(0, effective_taps() - 1));
                end else begin
                    idx = IDX_W'($urandom);
                end
                send_beat(k, random_word(), idx, random_word());
            end
            calm = 1'b0;
        end
        settle();
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= !calm && ($urandom_range(0, 99) < 11);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_filtered.size() == 0) begin
                $error("filtered: result with no expectation, actual %h", filtered);
                mismatches++;
            end else begin
                front_filtered = expected_filtered.pop_front();
                results_checked++;
                if (filtered !== front_filtered) begin
                    $error("filtered mismatch: expected %h actual %h", front_filtered, filtered);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("fir_q31_split_compute_shift regression: fail");
            $finish;
        end
    end

    initial begin
        foreach (hist_line[i]) hist_line[i] = '0;
        foreach (coef_bank[i]) coef_bank[i] = '0;
        tap_reg = TAPCNT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_coefficient_extremes();
        test_tap_count_limits();
        test_random_traffic();
        $display("covered %0d beats of all kinds, %0d filter results checked", beats_sent,
                 results_checked);
        $display("over %0d tap count writes, saturation at both ends included", taps_written);
        if (mismatches == 0) begin
            $display("fir_q31_split_compute_shift regression: pass");
        end else begin
            $display("fir_q31_split_compute_shift regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
src/fqcs_pkg.sv
src/fir_q31_split_compute_shift.sv
dv/fir_q31_split_compute_shift_tb.sv
